// File: src/bped_pkg.sv
// Shared detector constants: event codes, register indexes, reset values and flag bits.
package bped_pkg;

  // Event codes carried on the result channel
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_DOWN    = 3'd1;
  localparam logic [2:0] EV_LONG    = 3'd2;
  localparam logic [2:0] EV_PRESSED = 3'd3;
  localparam logic [2:0] EV_UP      = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_BUTTON_COUNT = 2'd0;
  localparam logic [1:0] REG_HANDLER_EN   = 2'd1;
  localparam logic [1:0] REG_LONG_PERIOD  = 2'd2;

  // Register reset values
  localparam logic [31:0] LONG_PERIOD_RST = 32'd1000;

  // Flag bit positions in the per-button state
  localparam int FLAG_DOWN = 0;
  localparam int FLAG_LONG = 1;

endpackage

// File: src/bped_if.sv
// Channel interfaces of the button press event detector: check input, event output, config writes.
interface bped_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  button_index;
  logic        first_level;
  logic        second_level;
  logic [31:0] now_tick;

  modport source (output valid, button_index, first_level, second_level, now_tick,
                  input ready);
  modport sink   (input valid, button_index, first_level, second_level, now_tick,
                  output ready);
endinterface

interface bped_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_button;
  logic [2:0] event_code;
  logic       last_of_run;
  logic       is_down;
  logic       is_long_down;

  modport source (output valid, event_button, event_code, last_of_run, is_down,
                  is_long_down, input ready);
  modport sink   (input valid, event_button, event_code, last_of_run, is_down,
                  is_long_down, output ready);
endinterface

interface bped_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: src/button_press_event_detector_core.sv
// Button press event detector core.
// in_chan carries one check of one button per item: index, active-low line level,
// the level sampled after the debounce delay and the current tick. out_chan returns
// one or two result items per check (event code, button, flags after the check);
// last_of_run marks the final result of a check. cfg_chan writes button_count,
// handler_enable and long_period_ticks and is always ready.
// Per-button state (down, long-down flags and press tick) lives in one memory with a
// registered read port. A check is read at acceptance, modified in the next cycle and
// written back as its results move to the output buffer; a one-entry bypass covers a
// check of the same button right behind it.
// The user writes cfg_chan only while idle; the block does not enforce it.
// Throughput: one check per cycle while each yields one result and the receiver takes
// it; the output port passes one result per cycle, so a check's two results hold back
// the next. Reset clears the flags of every button through per-entry valid bits (no sweep)
// and returns the registers to 0, 0 and 1000. When the receiver stalls the output
// buffer and an occupied check stage hold, and in_chan.ready drops.
module button_press_event_detector_core
  import bped_pkg::*;
#(
  parameter int MAX_BUTTONS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  bped_in_if.sink     in_chan,
  bped_out_if.source  out_chan,
  bped_cfg_if.sink    cfg_chan
);

  localparam int          IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam logic [5:0]  MAX_B = 6'(MAX_BUTTONS);

  typedef struct packed {
    logic [31:0] stamp;
    logic [1:0]  flags;
  } entry_t;

  typedef struct packed {
    logic [2:0] event_button;
    logic [2:0] event_code;
    logic       last_of_run;
    logic       is_down;
    logic       is_long_down;
  } res_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic        first;
    logic        second;
    logic [31:0] now;
  } chk_t;

  // Configuration registers
  logic [3:0]  cnt_r;
  logic [7:0]  en_r;
  logic [31:0] lp_r;

  // State memory and per-entry valid bits
  entry_t                 mem_r [MAX_BUTTONS];
  logic [MAX_BUTTONS-1:0] vld_r;
  entry_t                 rd_r;

  // Check stage
  logic       s1_vld_r;
  chk_t       s1_r;
  logic       s1_go;
  logic       in_acc;
  logic [IDX_W-1:0] in_addr;
  logic [IDX_W-1:0] s1_addr;

  // Write-back bypass
  logic             wb_vld_r;
  logic [IDX_W-1:0] wb_addr_r;
  entry_t           wb_data_r;

  // Output buffer
  logic [1:0] ob_cnt_r;
  res_t       ob0_r;
  res_t       ob1_r;
  logic       out_pop;

  // Stage results
  logic [5:0]  cnt_eff;
  logic        in_range;
  logic        held;
  entry_t      cur;
  entry_t      nxt_entry;
  logic [31:0] elapsed;
  logic        wr_en;
  logic [2:0]  ev0;
  logic [2:0]  ev1;
  logic [1:0]  nev;
  logic [1:0]  nres;
  res_t        res0;
  res_t        res1;

  // Handshakes
  assign cfg_chan.ready = 1'b1;
  assign s1_go          = s1_vld_r && ((ob_cnt_r == 2'd0) ||
                                       ((ob_cnt_r == 2'd1) && out_chan.ready));
  assign in_chan.ready  = !s1_vld_r || s1_go;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign out_pop        = out_chan.valid && out_chan.ready;
  assign in_addr        = IDX_W'(in_chan.button_index);
  assign s1_addr        = IDX_W'(s1_r.idx);

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      en_r  <= '0;
      lp_r  <= LONG_PERIOD_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.reg_index)
        REG_BUTTON_COUNT: cnt_r <= cfg_chan.wdata[3:0];
        REG_HANDLER_EN:   en_r  <= cfg_chan.wdata[7:0];
        REG_LONG_PERIOD:  lp_r  <= cfg_chan.wdata;
        default: ;
      endcase
    end
  end

  // Read on acceptance, write back an in-range check when it leaves the stage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= mem_r[in_addr];
    end
    if (s1_go && wr_en) begin
      mem_r[s1_addr] <= nxt_entry;
    end
  end

  // Valid bits, check stage and bypass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      s1_vld_r <= 1'b0;
      wb_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_go) begin
        wb_vld_r <= wr_en;
        if (wr_en) begin
          vld_r[s1_addr] <= 1'b1;
        end
      end
    end
  end

  // Check and bypass payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.idx    <= in_chan.button_index;
      s1_r.first  <= in_chan.first_level;
      s1_r.second <= in_chan.second_level;
      s1_r.now    <= in_chan.now_tick;
    end
    if (s1_go) begin
      wb_addr_r <= s1_addr;
      wb_data_r <= nxt_entry;
    end
  end

  // Evaluate one check against the button's state
  always_comb begin
    cnt_eff  = ({2'b00, cnt_r} > MAX_B) ? MAX_B : {2'b00, cnt_r};
    in_range = ({3'b000, s1_r.idx} < cnt_eff);
    held     = !s1_r.first && !s1_r.second;

    // take the entry written just behind this read, else the memory (flags clear if unwritten)
    if (wb_vld_r && (wb_addr_r == s1_addr)) begin
      cur = wb_data_r;
    end else if (vld_r[s1_addr]) begin
      cur = rd_r;
    end else begin
      cur = '{stamp: rd_r.stamp, flags: 2'b00};
    end

    elapsed   = s1_r.now - cur.stamp;
    nxt_entry = cur;
    ev0       = EV_NONE;
    ev1       = EV_NONE;
    nev       = 2'd0;

    if (held) begin
      if (!cur.flags[FLAG_DOWN]) begin
        nxt_entry.flags[FLAG_DOWN] = 1'b1;
        nxt_entry.stamp            = s1_r.now;
        ev0                        = EV_DOWN;
        nev                        = 2'd1;
      end else if (!cur.flags[FLAG_LONG] && (elapsed >= lp_r)) begin
        nxt_entry.flags[FLAG_LONG] = 1'b1;
        ev0                        = EV_LONG;
        nev                        = 2'd1;
      end
    end else if (cur.flags[FLAG_DOWN]) begin
      nxt_entry.flags = 2'b00;
      if (!cur.flags[FLAG_LONG]) begin
        ev0 = EV_PRESSED;
        ev1 = EV_UP;
        nev = 2'd2;
      end else begin
        ev0 = EV_UP;
        nev = 2'd1;
      end
    end

    wr_en = in_range;

    // build the results
    res0.event_button = s1_r.idx;
    res0.event_code   = EV_NONE;
    res0.last_of_run  = 1'b1;
    res0.is_down      = 1'b0;
    res0.is_long_down = 1'b0;
    res1              = res0;
    nres              = 2'd1;
    if (in_range) begin
      res0.is_down      = nxt_entry.flags[FLAG_DOWN];
      res0.is_long_down = nxt_entry.flags[FLAG_LONG];
      res1              = res0;
      if (en_r[s1_r.idx] && (nev != 2'd0)) begin
        res0.event_code  = ev0;
        res1.event_code  = ev1;
        res0.last_of_run = (nev == 2'd1);
        nres             = nev;
      end
    end
  end

  // Output buffer: load a whole check's results, pop one per handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= 2'd0;
    end else if (s1_go) begin
      ob_cnt_r <= nres;
    end else if (out_pop) begin
      ob_cnt_r <= ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      ob0_r <= res0;
      ob1_r <= res1;
    end else if (out_pop) begin
      ob0_r <= ob1_r;
    end
  end

  assign out_chan.valid        = (ob_cnt_r != 2'd0);
  assign out_chan.event_button = ob0_r.event_button;
  assign out_chan.event_code   = ob0_r.event_code;
  assign out_chan.last_of_run  = ob0_r.last_of_run;
  assign out_chan.is_down      = ob0_r.is_down;
  assign out_chan.is_long_down = ob0_r.is_long_down;

endmodule

// File: src/bped_checker.sv
// Port-level checks of the button press event detector and their binding to the top level.
module bped_checker
  import bped_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_code,
  input logic       last_of_run,
  input logic       is_down,
  input logic       is_long_down
);

  // Hold a result that was not taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A result without an event always ends its run
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_code == EV_NONE) |-> last_of_run)
    else $error("empty result not last of run");

  // A down event shows the button down and not yet long
  a_down_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_code == EV_DOWN) |-> is_down && !is_long_down && last_of_run)
    else $error("down event with wrong flags");

  // An up event clears both flags and ends the run
  a_up_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_code == EV_UP) |-> !is_down && !is_long_down && last_of_run)
    else $error("up event with wrong flags");

  // A pressed event never closes its run, as its up event follows
  a_pressed_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_code == EV_PRESSED) |-> !last_of_run)
    else $error("pressed event closes its run");

endmodule

bind button_press_event_detector_core bped_checker u_bped_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .event_code   (out_chan.event_code),
  .last_of_run  (out_chan.last_of_run),
  .is_down      (out_chan.is_down),
  .is_long_down (out_chan.is_long_down)
);
